[src/lattice_boltzmann_d1q2_diffusion_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the D1Q2 diffusion core
// Shared property shorthands, each checked on the rising clock edge and
// disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef LATTICE_BOLTZMANN_D1Q2_DIFFUSION_CORE_DEFINES_SVH
`define LATTICE_BOLTZMANN_D1Q2_DIFFUSION_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lbd_pkg.sv]
// ---------------------------------------------------------------------------
// D1Q2 diffusion core package
// Value types, opcodes, register indexes and the shared fixed-point helpers.
// ---------------------------------------------------------------------------
package lbd_pkg;

  // Signed Q8.16 values and the unsigned Q2.16 relaxation factor.
  localparam int VAL_W  = 24;
  localparam int RATE_W = 18;
  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = DIFF_W + RATE_W + 1;
  localparam int RND_W  = PROD_W - 16;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic        [RATE_W-1:0] rate_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  localparam int VAL_MAX = 8388607;
  localparam int VAL_MIN = -8388608;

  // Register reset values.
  localparam rate_t RELAX_RESET = 18'd87381;
  localparam val_t  WALL_RESET  = 24'sd65536;

  // Configuration register indexes.
  localparam logic CFG_RELAX = 1'b0;
  localparam logic CFG_WALL  = 1'b1;

  // Input opcodes; the fourth code does nothing and has no member.
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  // Clamp a wide signed value into the Q8.16 range.
  function automatic val_t sat_val(input logic signed [31:0] v);
    val_t r;
    if (v > 32'(VAL_MAX)) begin
      r = val_t'(VAL_MAX);
    end else if (v < 32'(VAL_MIN)) begin
      r = val_t'(VAL_MIN);
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  // Halve with rounding to nearest, ties away from zero.
  function automatic val_t half_val(input val_t v);
    logic signed [VAL_W:0] t;
    t = {v[VAL_W-1], v} + {{VAL_W{1'b0}}, ~v[VAL_W-1]};
    return t[VAL_W:1];
  endfunction

  // Drop sixteen fraction bits with rounding to nearest, ties away from zero.
  function automatic rnd_t round_q16(input prod_t p);
    prod_t bias;
    prod_t t;
    bias = p[PROD_W-1] ? prod_t'(16'h7FFF) : prod_t'(16'h8000);
    t    = p + bias;
    return t[PROD_W-1:16];
  endfunction

endpackage

[src/lbd_ram.sv]
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, with the read data registered.
// ---------------------------------------------------------------------------
module lbd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/lattice_boltzmann_d1q2_diffusion_core.sv]
// ---------------------------------------------------------------------------
// D1Q2 lattice Boltzmann diffusion core
// A one-dimensional two-velocity diffusion grid held in three RAMs. Items
// load a node, advance the whole grid by one time step, or read a node.
//
//   Channel  Direction  Handshake                Beat contents
//   in       sink       in_valid_i / in_stall_o  op_i, node_i, density_in_i
//   out      source     out_valid_o/out_stall_i  density_out_o
//   cfg      sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// After reset a clearing pass zeroes all three RAMs; input beats stall during
// it, configuration writes are taken.
// Write and no-op items go from idle to the result state; reads pass through
// the read state first. An advance makes one RAM read per node, set by the
// single read port of each population RAM, plus the four-stage collision pipeline.
// A finished result waits in the output register while the next beat is taken.
// ---------------------------------------------------------------------------
`include "lattice_boltzmann_d1q2_diffusion_core_defines.svh"

module lattice_boltzmann_d1q2_diffusion_core #(
  parameter int NODES = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [23:0]             cfg_data_i,
  // Input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              op_i,
  input  logic [6:0]              node_i,
  input  logic signed [23:0]      density_in_i,
  // Output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [23:0]      density_out_o
);

  localparam int AW = $clog2(NODES);
  localparam logic [AW-1:0] LAST = AW'(NODES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_TAIL,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  lbd_pkg::rate_t relax_q;
  lbd_pkg::val_t  wall_q;

  // Control registers.
  logic [AW-1:0] cnt_q;
  logic          issue_on_q;
  logic          rd_ok_q;
  logic          out_valid_q;
  logic          p1_valid_q, s1_valid_q, s2_valid_q, s3_valid_q;

  // Payload registers.
  lbd_pkg::val_t  res_q;
  lbd_pkg::val_t  density_out_q;
  logic [AW-1:0]  p1_idx_q, s1_idx_q, s2_idx_q, s3_idx_q;
  lbd_pkg::val_t  s1_r_q, s1_l_q, s1_rho_q;
  lbd_pkg::diff_t s1_dr_q, s1_dl_q;
  lbd_pkg::val_t  s2_r_q, s2_l_q;
  lbd_pkg::prod_t s2_pr_q, s2_pl_q;
  lbd_pkg::val_t  s3_r_q, s3_l_q;
  lbd_pkg::val_t  rprev1_q, rprev2_q, lprev1_q;

  // RAM ports.
  logic          r_we, l_we, d_we;
  logic [AW-1:0] r_waddr, l_waddr, d_waddr, d_raddr;
  lbd_pkg::val_t r_wdata, l_wdata, d_wdata;
  lbd_pkg::val_t r_rdata, l_rdata, d_rdata;

  // Handshake and decode.
  logic          in_accept;
  logic          out_free;
  logic          in_range;
  logic [AW-1:0] node_addr;
  lbd_pkg::op_e  op;
  logic          issue;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_range    = (32'(node_i) < NODES);
  assign node_addr   = AW'(node_i);
  assign op          = lbd_pkg::op_e'(op_i);
  assign issue       = (state_q == ST_SWEEP) && issue_on_q;
  assign out_valid_o = out_valid_q;
  assign density_out_o = density_out_q;

  // Collision, first stage: density, equilibrium and both differences.
  lbd_pkg::val_t  p1_rho, p1_eq;
  lbd_pkg::diff_t p1_dr, p1_dl;

  always_comb begin
    p1_rho = lbd_pkg::sat_val(32'(r_rdata) + 32'(l_rdata));
    p1_eq  = lbd_pkg::half_val(p1_rho);
    p1_dr  = lbd_pkg::DIFF_W'(p1_eq) - lbd_pkg::DIFF_W'(r_rdata);
    p1_dl  = lbd_pkg::DIFF_W'(p1_eq) - lbd_pkg::DIFF_W'(l_rdata);
  end

  // Collision, third stage: rounded relaxation step added back.
  lbd_pkg::val_t p3_r, p3_l;

  always_comb begin
    p3_r = lbd_pkg::sat_val(32'(s2_r_q) + 32'(lbd_pkg::round_q16(s2_pr_q)));
    p3_l = lbd_pkg::sat_val(32'(s2_l_q) + 32'(lbd_pkg::round_q16(s2_pl_q)));
  end

  // Wall condition at node zero uses the left population streamed there.
  lbd_pkg::val_t wall_r;
  lbd_pkg::val_t half_in;

  assign wall_r  = lbd_pkg::sat_val(32'(wall_q) - 32'(s3_l_q));
  assign half_in = lbd_pkg::half_val(density_in_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (op)
            lbd_pkg::OP_ADVANCE: state_d = ST_SWEEP;
            lbd_pkg::OP_READ:    state_d = ST_READ;
            default:             state_d = ST_RESULT;
          endcase
        end
      end
      ST_READ:  state_d = ST_RESULT;
      ST_SWEEP: begin
        if (s3_valid_q && (s3_idx_q == LAST)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL:  state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // RAM write selection per state.
  always_comb begin
    r_we    = 1'b0;
    l_we    = 1'b0;
    d_we    = 1'b0;
    r_waddr = cnt_q;
    l_waddr = cnt_q;
    d_waddr = cnt_q;
    r_wdata = '0;
    l_wdata = '0;
    d_wdata = '0;
    d_raddr = node_addr;
    unique case (state_q)
      ST_CLEAR: begin
        r_we = 1'b1;
        l_we = 1'b1;
        d_we = 1'b1;
      end
      ST_IDLE: begin
        if (in_accept && (op == lbd_pkg::OP_WRITE) && in_range) begin
          r_we    = 1'b1;
          l_we    = 1'b1;
          d_we    = 1'b1;
          r_waddr = node_addr;
          l_waddr = node_addr;
          d_waddr = node_addr;
          r_wdata = half_in;
          l_wdata = half_in;
          d_wdata = density_in_i;
        end
      end
      ST_SWEEP: begin
        // Density is stored as soon as the first stage has it.
        d_we    = s1_valid_q;
        d_waddr = s1_idx_q;
        d_wdata = s1_rho_q;
        // Streamed populations land one node behind the collision front.
        if (s3_valid_q && (s3_idx_q != '0)) begin
          r_we    = 1'b1;
          l_we    = 1'b1;
          r_waddr = AW'(s3_idx_q - AW'(1));
          l_waddr = AW'(s3_idx_q - AW'(1));
          r_wdata = (s3_idx_q == AW'(1)) ? wall_r : rprev2_q;
          l_wdata = (s3_idx_q == LAST) ? lprev1_q : s3_l_q;
        end
      end
      ST_TAIL: begin
        // Zero-gradient copy into the last node.
        r_we    = 1'b1;
        l_we    = 1'b1;
        r_waddr = LAST;
        l_waddr = LAST;
        r_wdata = rprev2_q;
        l_wdata = lprev1_q;
      end
      default: begin
        r_we = 1'b0;
      end
    endcase
  end

  // State, control and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      issue_on_q  <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      p1_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      p1_valid_q <= issue;
      s1_valid_q <= p1_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (state_q == ST_CLEAR) begin
        cnt_q <= (cnt_q == LAST) ? '0 : AW'(cnt_q + AW'(1));
      end else if (state_q == ST_IDLE && in_accept && op == lbd_pkg::OP_ADVANCE) begin
        cnt_q      <= '0;
        issue_on_q <= 1'b1;
      end else if (issue) begin
        cnt_q <= AW'(cnt_q + AW'(1));
        if (cnt_q == LAST) begin
          issue_on_q <= 1'b0;
        end
      end
      if (in_accept) begin
        rd_ok_q <= in_range;
      end
      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= lbd_pkg::RELAX_RESET;
      wall_q  <= lbd_pkg::WALL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbd_pkg::CFG_RELAX: relax_q <= cfg_data_i[lbd_pkg::RATE_W-1:0];
        lbd_pkg::CFG_WALL:  wall_q  <= cfg_data_i;
        default:            relax_q <= relax_q;
      endcase
    end
  end

  // Result register and output beat payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_accept) begin
      res_q <= '0;
    end else if (state_q == ST_READ) begin
      res_q <= rd_ok_q ? d_rdata : '0;
    end else if (state_q == ST_TAIL) begin
      res_q <= '0;
    end
    if (state_q == ST_RESULT && out_free) begin
      density_out_q <= res_q;
    end
  end

  // Collision pipeline and streaming history.
  always_ff @(posedge clk_i) begin
    p1_idx_q <= cnt_q;
    s1_idx_q <= p1_idx_q;
    s1_r_q   <= r_rdata;
    s1_l_q   <= l_rdata;
    s1_rho_q <= p1_rho;
    s1_dr_q  <= p1_dr;
    s1_dl_q  <= p1_dl;
    s2_idx_q <= s1_idx_q;
    s2_r_q   <= s1_r_q;
    s2_l_q   <= s1_l_q;
    s2_pr_q  <= s1_dr_q * $signed({1'b0, relax_q});
    s2_pl_q  <= s1_dl_q * $signed({1'b0, relax_q});
    s3_idx_q <= s2_idx_q;
    s3_r_q   <= p3_r;
    s3_l_q   <= p3_l;
    // The last node does not shift the history, so the tail sees its
    // two lower neighbors.
    if (s3_valid_q && (s3_idx_q != LAST)) begin
      rprev1_q <= s3_r_q;
      rprev2_q <= rprev1_q;
      lprev1_q <= s3_l_q;
    end
  end

  // Population and density stores.
  lbd_ram #(
    .WIDTH (lbd_pkg::VAL_W),
    .DEPTH (NODES)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (cnt_q),
    .rdata_o (r_rdata)
  );

  lbd_ram #(
    .WIDTH (lbd_pkg::VAL_W),
    .DEPTH (NODES)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (cnt_q),
    .rdata_o (l_rdata)
  );

  lbd_ram #(
    .WIDTH (lbd_pkg::VAL_W),
    .DEPTH (NODES)
  ) u_density_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  // Streaming writes never land on the node being fetched.
  `LBD_ASSERT_SAME(a_no_rw_overlap, clk_i, rst_ni, issue && r_we, r_waddr != cnt_q && l_waddr != cnt_q, "sweep write hits the node being read")
  // Collision data only flows during a sweep.
  `LBD_ASSERT_SAME(a_pipe_in_sweep, clk_i, rst_ni, s3_valid_q || s1_valid_q, state_q == ST_SWEEP, "collision pipeline active outside a sweep")
  // A posted result leaves the core idle with a valid output beat.
  `LBD_ASSERT_NEXT(a_result_posted, clk_i, rst_ni, state_q == ST_RESULT && out_free, state_q == ST_IDLE && out_valid_q, "result not posted to the output register")

endmodule
